// ===== hdl/jsu_pkg.sv =====
// jsu_pkg: shared types, constants and helper functions of the json string unescaper
// used by jsu_front, jsu_fifo, jsu_back and json_string_unescape_utf8; no dependencies
package jsu_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);
  localparam int unsigned CpW    = 21;

  // result kind codes as seen on tuser
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  // top six bits of a high and a low surrogate
  localparam logic [5:0] SUR_HIGH = 6'b110110;
  localparam logic [5:0] SUR_LOW  = 6'b110111;
  localparam logic [CpW-1:0] CP_PLANE1 = 21'h10000;

  // what the back end has to do with one queue entry
  typedef enum logic [1:0] {
    ENT_RAW   = 2'd0,
    ENT_CP    = 2'd1,
    ENT_CLOSE = 2'd2,
    ENT_ERROR = 2'd3
  } ent_kind_e;

  typedef struct packed {
    ent_kind_e        kind;
    logic [CpW-1:0]   val;
  } entry_t;

  typedef enum logic [6:0] {
    MODE_WAIT   = 7'b0000001,
    MODE_STR    = 7'b0000010,
    MODE_ESC    = 7'b0000100,
    MODE_HEX1   = 7'b0001000,
    MODE_WANTBS = 7'b0010000,
    MODE_WANTU  = 7'b0100000,
    MODE_HEX2   = 7'b1000000
  } mode_e;

  // bit 4 flags a valid hex digit, bits 3:0 its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // number of result bytes minus one
  function automatic logic [1:0] ent_len(input entry_t e);
    logic [1:0] n;
    n = 2'd0;
    if (e.kind == ENT_CP) begin
      if (e.val < 21'h80) begin
        n = 2'd0;
      end else if (e.val < 21'h800) begin
        n = 2'd1;
      end else if (e.val < 21'h10000) begin
        n = 2'd2;
      end else begin
        n = 2'd3;
      end
    end
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [CpW-1:0] cp, input logic [1:0] len,
                                           input logic [1:0] idx);
    logic [7:0] b;
    b = cp[7:0];
    case (len)
      2'd1: begin
        b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      end
      2'd2: begin
        case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      2'd3: begin
        case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: b = cp[7:0];
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/jsu_front.sv =====
// jsu_front: byte parser; tracks string and escape state and emits one queue entry
// per input byte that gives results. depends on jsu_pkg
module jsu_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      in_byte_i,
  input  logic            in_eot_i,
  input  logic            q_full_i,
  output logic            in_ready_o,
  output logic            push_o,
  output jsu_pkg::entry_t push_ent_o
);
  import jsu_pkg::*;

  mode_e       mode_q, mode_d;
  logic [15:0] accum_q, accum_d;
  logic [1:0]  digits_q, digits_d;
  logic [9:0]  held_q, held_d;

  logic        accept;
  logic        res_v;
  logic        ended;
  entry_t      res;
  logic [4:0]  hd;
  logic [15:0] acc_new;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign hd         = hex_digit(in_byte_i);
  assign acc_new    = {accum_q[11:0], hd[3:0]};

  always_comb begin
    mode_d   = mode_q;
    accum_d  = accum_q;
    digits_d = digits_q;
    held_d   = held_q;
    res_v    = 1'b0;
    ended    = 1'b0;
    res      = '{kind: ENT_ERROR, val: '0};
    case (mode_q)
      MODE_STR: begin
        if (in_byte_i == CH_QUOTE) begin
          res_v = 1'b1; ended = 1'b1; res.kind = ENT_CLOSE; mode_d = MODE_WAIT;
        end else if (in_byte_i == CH_BSL) begin
          mode_d = MODE_ESC;
        end else if (in_byte_i < CH_SPACE) begin
          res_v = 1'b1; ended = 1'b1; mode_d = MODE_WAIT;
        end else begin
          res_v = 1'b1; res.kind = ENT_RAW; res.val = CpW'(in_byte_i);
        end
      end
      MODE_ESC: begin
        mode_d   = MODE_STR;
        res_v    = 1'b1;
        res.kind = ENT_RAW;
        case (in_byte_i)
          CH_QUOTE, CH_BSL, CH_SLASH: res.val = CpW'(in_byte_i);
          CH_B: res.val = CpW'(8'h08);
          CH_F: res.val = CpW'(8'h0C);
          CH_N: res.val = CpW'(8'h0A);
          CH_R: res.val = CpW'(8'h0D);
          CH_T: res.val = CpW'(8'h09);
          CH_U: begin
            res_v = 1'b0; mode_d = MODE_HEX1; accum_d = '0; digits_d = '0;
          end
          default: begin
            res.kind = ENT_ERROR; ended = 1'b1; mode_d = MODE_WAIT;
          end
        endcase
      end
      MODE_HEX1, MODE_HEX2: begin
        if (!hd[4]) begin
          res_v = 1'b1; ended = 1'b1; mode_d = MODE_WAIT;
        end else begin
          accum_d = acc_new;
          if (digits_q != 2'd3) begin
            digits_d = digits_q + 2'd1;
          end else begin
            digits_d = '0;
            if (mode_q == MODE_HEX1) begin
              if (acc_new[15:10] == SUR_HIGH) begin
                held_d = acc_new[9:0];
                mode_d = MODE_WANTBS;
              end else if (acc_new[15:10] == SUR_LOW) begin
                res_v = 1'b1; ended = 1'b1; mode_d = MODE_WAIT;
              end else begin
                res_v = 1'b1; res.kind = ENT_CP; res.val = CpW'(acc_new); mode_d = MODE_STR;
              end
            end else begin
              if (acc_new[15:10] != SUR_LOW) begin
                res_v = 1'b1; ended = 1'b1; mode_d = MODE_WAIT;
              end else begin
                res_v    = 1'b1;
                res.kind = ENT_CP;
                res.val  = CP_PLANE1 + CpW'({held_q, acc_new[9:0]});
                mode_d   = MODE_STR;
              end
            end
          end
        end
      end
      MODE_WANTBS: begin
        if (in_byte_i != CH_BSL) begin
          res_v = 1'b1; ended = 1'b1; mode_d = MODE_WAIT;
        end else begin
          mode_d = MODE_WANTU;
        end
      end
      MODE_WANTU: begin
        if (in_byte_i != CH_U) begin
          res_v = 1'b1; ended = 1'b1; mode_d = MODE_WAIT;
        end else begin
          mode_d = MODE_HEX2; accum_d = '0; digits_d = '0;
        end
      end
      default: begin
        mode_d = MODE_WAIT;
        if (in_byte_i == CH_SPACE || in_byte_i == CH_TAB ||
            in_byte_i == CH_LF || in_byte_i == CH_CR) begin
          mode_d = MODE_WAIT;
        end else if (in_byte_i == CH_QUOTE) begin
          mode_d = MODE_STR;
        end else begin
          res_v = 1'b1; ended = 1'b1;
        end
      end
    endcase
    // end of text inside an open string or while waiting replaces any output
    if (in_eot_i && !ended) begin
      res_v  = 1'b1;
      res    = '{kind: ENT_ERROR, val: '0};
      mode_d = MODE_WAIT;
    end
  end

  assign push_o     = accept && res_v;
  assign push_ent_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_WAIT;
      accum_q  <= '0;
      digits_q <= '0;
      held_q   <= '0;
    end else if (accept) begin
      mode_q   <= mode_d;
      accum_q  <= accum_d;
      digits_q <= digits_d;
      held_q   <= held_d;
    end
  end

endmodule

// ===== hdl/jsu_fifo.sv =====
// jsu_fifo: short queue of parsed entries between the parser and the serialiser
// depends on jsu_pkg
module jsu_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  jsu_pkg::entry_t push_ent_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output jsu_pkg::entry_t head_o
);
  import jsu_pkg::*;

  entry_t           ent_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = ent_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= push_ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

// ===== hdl/jsu_back.sv =====
// jsu_back: serialiser; turns queue entries into result bytes, one per cycle
// while the receiver is ready, via a registered output stage. depends on jsu_pkg
module jsu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  jsu_pkg::entry_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      out_kind_o,
  output logic            out_last_o
);
  import jsu_pkg::*;

  logic       valid_q;
  logic [7:0] byte_q, byte_d;
  logic [1:0] kind_q, kind_d;
  logic       last_q, last_d;
  logic [1:0] idx_q;
  logic [1:0] len;
  logic       load;

  assign len    = ent_len(head_i);
  assign load   = !empty_i && (!valid_q || out_ready_i);
  assign last_d = (idx_q == len);
  assign pop_o  = load && last_d;

  always_comb begin
    byte_d = utf8_byte(head_i.val, len, idx_q);
    case (head_i.kind)
      ENT_CLOSE: begin kind_d = KIND_CLOSE; byte_d = '0; end
      ENT_ERROR: begin kind_d = KIND_ERROR; byte_d = '0; end
      default:   kind_d = KIND_DATA;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= last_d ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      kind_q <= kind_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_kind_o  = kind_q;
  assign out_last_o  = last_q;

endmodule

// ===== hdl/json_string_unescape_utf8.sv =====
// json_string_unescape_utf8: top level of the streaming json string unescaper
// instantiates jsu_front, jsu_fifo and jsu_back; depends on jsu_pkg
//
// usage:
//   the slave channel takes raw json text, one byte per transaction, tlast set on
//   the final byte of the text. the master channel gives results: tdata is the
//   decoded byte, tuser the kind (data, string closed, malformed string) and
//   tlast marks the final result caused by one input byte.
//   a byte is taken every cycle while the four-entry queue between parser and
//   serialiser has room; the serialiser sends one result byte per cycle while
//   the receiver is ready; an escape to n utf-8 bytes holds the master side for all n.
//   the first result of a byte reaches m_axis_tvalid via the queue and output register.
//   when the receiver stalls the output register holds, the queue fills, and
//   s_axis_tready falls once it holds four entries; nothing is lost.
//   reset clears the queue and output stage and leaves the parser waiting for
//   an opening quote.
module json_string_unescape_utf8 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // end_of_text
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser_o,   // [1:0] kind
  output logic       m_axis_tlast_o    // last_in_run
);
  import jsu_pkg::*;

  logic   push, pop, full, empty;
  entry_t push_ent, head;

  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_byte_i  (s_axis_tdata_i),
    .in_eot_i   (s_axis_tlast_i),
    .q_full_i   (full),
    .in_ready_o (s_axis_tready_o),
    .push_o     (push),
    .push_ent_o (push_ent)
  );

  jsu_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_ent_i (push_ent),
    .pop_i      (pop),
    .full_o     (full),
    .empty_o    (empty),
    .head_o     (head)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_kind_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// ===== sim/testbench.sv =====
// testbench: self-checking bench for json_string_unescape_utf8 with its own decoder model
// random idles on both stream sides; depends on jsu_pkg and the rtl of the block
`timescale 1ns / 1ps

module testbench;
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    P_WAIT, P_STR, P_ESC, P_HEX1, P_WANTBS, P_WANTU, P_HEX2
  } parse_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eot;
    logic       hold;   // sender waits for every result before this byte
    logic       quiet;  // no idling while this byte is in play
  } text_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  text_item_t  text_bytes[$];
  result_t     expected_out[$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_queued = 0;
  logic        hold_next = 1'b0;
  logic        cur_quiet = 1'b0;
  logic        quiet_phase = 1'b0;
  logic [3:0]  tx_wait = 4'd0;
  logic [3:0]  rx_wait = 4'd0;

  // decoder model state
  parse_mode_e dec_mode = P_WAIT;
  logic [15:0] dec_acc = 16'd0;
  logic [1:0]  dec_digits = 2'd0;
  logic [9:0]  dec_high = 10'd0;
  result_t     run_buf[4];
  int          run_len;
  logic        run_ended;

  json_string_unescape_utf8 uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    mismatch_count++;
    $display("%0t ns: %s got %0h want %0h", $time, what, got, want);
  endtask

  // ---------------- decoder model ----------------

  function automatic void put_result(input logic [7:0] b, input logic [1:0] kind);
    if (run_len < 4) begin
      run_buf[run_len] = '{b, kind, 1'b0};
      run_len++;
    end
  endfunction

  function automatic void abort_string();
    put_result(8'd0, KIND_ERROR);
    dec_mode  = P_WAIT;
    run_ended = 1'b1;
  endfunction

  function automatic void put_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      put_result(cp[7:0], KIND_DATA);
    end else if (cp < 21'h800) begin
      put_result({3'b110, cp[10:6]}, KIND_DATA);
      put_result({2'b10, cp[5:0]}, KIND_DATA);
    end else if (cp < 21'h10000) begin
      put_result({4'b1110, cp[15:12]}, KIND_DATA);
      put_result({2'b10, cp[11:6]}, KIND_DATA);
      put_result({2'b10, cp[5:0]}, KIND_DATA);
    end else begin
      put_result({5'b11110, cp[20:18]}, KIND_DATA);
      put_result({2'b10, cp[17:12]}, KIND_DATA);
      put_result({2'b10, cp[11:6]}, KIND_DATA);
      put_result({2'b10, cp[5:0]}, KIND_DATA);
    end
  endfunction

  function automatic void decode_text_byte(input logic [7:0] c, input logic eot);
    logic [3:0] nib;
    logic       nib_ok;
    run_len   = 0;
    run_ended = 1'b0;
    case (dec_mode)
      P_STR: begin
        if (c == CH_QUOTE) begin
          put_result(8'd0, KIND_CLOSE);
          dec_mode  = P_WAIT;
          run_ended = 1'b1;
        end else if (c == CH_BSL) begin
          dec_mode = P_ESC;
        end else if (c < CH_SPACE) begin
          abort_string();
        end else begin
          put_result(c, KIND_DATA);
        end
      end
      P_ESC: begin
        dec_mode = P_STR;
        case (c)
          CH_QUOTE, CH_BSL, CH_SLASH: put_result(c, KIND_DATA);
          CH_B: put_result(8'h08, KIND_DATA);
          CH_F: put_result(8'h0C, KIND_DATA);
          CH_N: put_result(8'h0A, KIND_DATA);
          CH_R: put_result(8'h0D, KIND_DATA);
          CH_T: put_result(8'h09, KIND_DATA);
          CH_U: begin
            dec_mode   = P_HEX1;
            dec_acc    = 16'd0;
            dec_digits = 2'd0;
          end
          default: abort_string();
        endcase
      end
      P_HEX1, P_HEX2: begin
        nib    = 4'd0;
        nib_ok = 1'b1;
        if (c >= 8'h30 && c <= 8'h39) begin
          nib = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
          nib = c[3:0] + 4'd9;
        end else begin
          nib_ok = 1'b0;
        end
        if (!nib_ok) begin
          abort_string();
        end else begin
          dec_acc = {dec_acc[11:0], nib};
          if (dec_digits != 2'd3) begin
            dec_digits = dec_digits + 2'd1;
          end else begin
            dec_digits = 2'd0;
            if (dec_mode == P_HEX1) begin
              if (dec_acc >= 16'hD800 && dec_acc <= 16'hDBFF) begin
                dec_high = dec_acc[9:0];
                dec_mode = P_WANTBS;
              end else if (dec_acc >= 16'hDC00 && dec_acc <= 16'hDFFF) begin
                abort_string();
              end else begin
                put_utf8({5'd0, dec_acc});
                dec_mode = P_STR;
              end
            end else if (dec_acc < 16'hDC00 || dec_acc > 16'hDFFF) begin
              abort_string();
            end else begin
              put_utf8(21'h10000 + {1'b0, dec_high, dec_acc[9:0]});
              dec_mode = P_STR;
            end
          end
        end
      end
      P_WANTBS: begin
        if (c != CH_BSL) abort_string();
        else dec_mode = P_WANTU;
      end
      P_WANTU: begin
        if (c != CH_U) begin
          abort_string();
        end else begin
          dec_mode   = P_HEX2;
          dec_acc    = 16'd0;
          dec_digits = 2'd0;
        end
      end
      default: begin
        dec_mode = P_WAIT;
        if (c == CH_QUOTE) begin
          dec_mode = P_STR;
        end else if (!(c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR)) begin
          put_result(8'd0, KIND_ERROR);
          run_ended = 1'b1;
        end
      end
    endcase
    // end of text inside an open string or while waiting drops whatever the byte decoded
    if (eot && !run_ended) begin
      run_len = 0;
      put_result(8'd0, KIND_ERROR);
      dec_mode = P_WAIT;
    end
    if (run_len > 0) run_buf[run_len-1].last = 1'b1;
    for (int i = 0; i < run_len; i++) expected_out.insert(expected_out.size(), run_buf[i]);
  endfunction

  // ---------------- stimulus ----------------

  function automatic void push_byte(input logic [7:0] b, input logic eot);
    text_item_t it;
    it = '{b, eot, hold_next, cur_quiet};
    hold_next = 1'b0;
    bytes_queued++;
    text_bytes.insert(text_bytes.size(), it);
  endfunction

  // hex digit with random letter case
  function automatic logic [7:0] nib_ascii(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) ch = 8'h30 + nib;
    else ch = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
    return ch;
  endfunction

  function automatic void push_escaped_code(input logic [15:0] v);
    push_byte(CH_BSL, 1'b0);
    push_byte(CH_U, 1'b0);
    for (int i = 3; i >= 0; i--) push_byte(nib_ascii(v[i*4 +: 4]), 1'b0);
  endfunction

  task automatic push_token(output logic broke);
    int          r;
    int          k;
    int          j;
    logic [15:0] v;
    logic [7:0]  b;
    broke = 1'b0;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 5);
    if (r < 35) begin
      b = 8'($urandom_range(8'h20, 8'h7F));
      if (b == CH_QUOTE || b == CH_BSL) b = 8'h7E;
      push_byte(b, 1'b0);
    end else if (r < 45) begin
      push_byte(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
    end else if (r < 65) begin
      push_byte(CH_BSL, 1'b0);
      case ($urandom_range(0, 7))
        0:       b = CH_QUOTE;
        1:       b = CH_BSL;
        2:       b = CH_SLASH;
        3:       b = CH_B;
        4:       b = CH_F;
        5:       b = CH_N;
        6:       b = CH_R;
        default: b = CH_T;
      endcase
      push_byte(b, 1'b0);
    end else if (r < 85) begin
      case (k)
        0: push_escaped_code(16'($urandom_range(16'h0000, 16'h007F)));
        1: push_escaped_code(16'($urandom_range(16'h0080, 16'h07FF)));
        2: begin
          v = 16'($urandom_range(16'h0800, 16'hFFFF));
          if (v >= 16'hD800 && v <= 16'hDFFF) v = v ^ 16'h4000;
          push_escaped_code(v);
        end
        3: begin
          case ($urandom_range(0, 5))
            0: push_escaped_code(16'h0000);
            1: push_escaped_code(16'hFFFF);
            2: push_escaped_code(16'h007F);
            3: push_escaped_code(16'h0080);
            4: push_escaped_code(16'h07FF);
            default: push_escaped_code(16'h0800);
          endcase
        end
        default: begin
          // surrogate pair, now and then at the ends of the range
          case ($urandom_range(0, 3))
            0: begin
              push_escaped_code(16'hDBFF);
              push_escaped_code(16'hDFFF);
            end
            1: begin
              push_escaped_code(16'hD800);
              push_escaped_code(16'hDC00);
            end
            default: begin
              push_escaped_code(16'hD800 + 16'($urandom_range(0, 1023)));
              push_escaped_code(16'hDC00 + 16'($urandom_range(0, 1023)));
            end
          endcase
        end
      endcase
    end else if (r < 95) begin
      broke = 1'b1;
      case (k)
        0: begin
          push_byte(CH_BSL, 1'b0);
          case ($urandom_range(0, 5))
            0:       b = 8'h61;
            1:       b = 8'h55;
            2:       b = 8'h30;
            3:       b = 8'h00;
            4:       b = 8'hFF;
            default: b = 8'h27;
          endcase
          push_byte(b, 1'b0);
        end
        1: begin
          push_byte(CH_BSL, 1'b0);
          push_byte(CH_U, 1'b0);
          j = $urandom_range(0, 3);
          for (int i = 0; i < j; i++) push_byte(nib_ascii(4'($urandom_range(0, 15))), 1'b0);
          // just outside the digit and letter ranges
          case ($urandom_range(0, 7))
            0:       b = 8'h2F;
            1:       b = 8'h3A;
            2:       b = 8'h40;
            3:       b = 8'h47;
            4:       b = 8'h60;
            5:       b = 8'h67;
            6:       b = 8'h00;
            default: b = 8'hFF;
          endcase
          push_byte(b, 1'b0);
        end
        2: push_escaped_code(16'hDC00 + 16'($urandom_range(0, 1023)));
        3: begin
          push_escaped_code(16'hD800 + 16'($urandom_range(0, 1023)));
          b = 8'($urandom_range(0, 255));
          if (b == CH_BSL) b = 8'h41;
          push_byte(b, 1'b0);
        end
        4: begin
          push_escaped_code(16'hD800 + 16'($urandom_range(0, 1023)));
          push_byte(CH_BSL, 1'b0);
          push_byte($urandom_range(0, 1) ? 8'h55 : CH_N, 1'b0);
        end
        default: begin
          push_escaped_code(16'hD800 + 16'($urandom_range(0, 1023)));
          if ($urandom_range(0, 1)) push_escaped_code(16'($urandom_range(16'h0000, 16'hDBFF)));
          else push_escaped_code(16'($urandom_range(16'hE000, 16'hFFFF)));
        end
      endcase
    end else begin
      broke = 1'b1;
      push_byte(8'($urandom_range(0, 31)), 1'b0);
    end
  endtask

  // ---------------- driver ----------------

  always @(posedge clk_i or negedge rst_ni) begin : text_driver
    text_item_t nxt;
    int         gap;
    if (!rst_ni) begin
      s_tvalid    <= 1'b0;
      s_tdata     <= 8'd0;
      s_tlast     <= 1'b0;
      tx_wait     <= 4'd0;
      quiet_phase <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) decode_text_byte(s_tdata, s_tlast);
      if (tx_wait != 4'd0) begin
        tx_wait  <= tx_wait - 4'd1;
        s_tvalid <= 1'b0;
      end else if (text_bytes.size() != 0 &&
                   !(text_bytes[0].hold && expected_out.size() != 0)) begin
        nxt = text_bytes.pop_front();
        gap = nxt.quiet ? 0 : $urandom_range(0, 13);
        s_tvalid    <= 1'b1;
        s_tdata     <= nxt.data;
        s_tlast     <= nxt.eot;
        quiet_phase <= nxt.quiet;
        tx_wait     <= 4'(gap);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    result_t    want;
    logic [3:0] wait_n;
    if (!rst_ni) begin
      m_tready <= 1'b0;
      rx_wait  <= 4'd0;
    end else begin
      wait_n = rx_wait;
      if (m_tvalid && m_tready) begin
        if (expected_out.size() == 0) begin
          flag_mismatch("result with nothing expected, byte", m_tdata, 8'd0);
        end else begin
          want = expected_out.pop_front();
          if (m_tdata !== want.data) flag_mismatch("out_byte", m_tdata, want.data);
          if (m_tuser !== want.kind) flag_mismatch("kind", 8'(m_tuser), 8'(want.kind));
          if (m_tlast !== want.last) flag_mismatch("last_in_run", 8'(m_tlast), 8'(want.last));
        end
        wait_n = quiet_phase ? 4'd0 : 4'($urandom_range(0, 13));
      end else if (wait_n != 4'd0) begin
        wait_n = wait_n - 4'd1;
      end
      rx_wait  <= wait_n;
      m_tready <= (wait_n == 4'd0);
    end
  end

  // ---------------- sequence ----------------

  initial begin : main_sequence
    logic broke;
    int   n;
    int   e;
    logic hold_done;
    hold_done = 1'b0;

    // whitespace, a stray byte, raw bytes at the extremes, a raw control byte
    push_byte(CH_SPACE, 1'b0);
    push_byte(CH_TAB, 1'b0);
    push_byte(CH_CR, 1'b0);
    push_byte(CH_LF, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(CH_QUOTE, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h00, 1'b0);
    // surrogate pair with mixed-case hex, then a close
    push_byte(CH_QUOTE, 1'b0);
    push_byte(CH_BSL, 1'b0);
    push_byte(CH_U, 1'b0);
    push_byte(8'h44, 1'b0);
    push_byte(8'h38, 1'b0);
    push_byte(8'h33, 1'b0);
    push_byte(8'h64, 1'b0);
    push_byte(CH_BSL, 1'b0);
    push_byte(CH_U, 1'b0);
    push_byte(8'h64, 1'b0);
    push_byte(8'h65, 1'b0);
    push_byte(8'h30, 1'b0);
    push_byte(8'h30, 1'b0);
    push_byte(CH_QUOTE, 1'b0);
    // opening quote as the final byte of the text
    push_byte(CH_QUOTE, 1'b1);

    while (bytes_queued < 250) begin
      if ($urandom_range(0, 9) == 0) begin
        cur_quiet = 1'b0;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
      end else begin
        cur_quiet = ($urandom_range(0, 4) == 0);
        if (!hold_done && bytes_queued > 150) begin
          hold_next = 1'b1;
          hold_done = 1'b1;
        end
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0:       push_byte(CH_SPACE, 1'b0);
            1:       push_byte(CH_TAB, 1'b0);
            2:       push_byte(CH_LF, 1'b0);
            default: push_byte(CH_CR, 1'b0);
          endcase
        end
        push_byte(CH_QUOTE, 1'b0);
        n = $urandom_range(0, 6);
        broke = 1'b0;
        for (int i = 0; i < n && !broke; i++) push_token(broke);
        if (!broke) begin
          e = $urandom_range(0, 9);
          // text cut short inside the string, closed at the end of text, or closed
          if (e == 0) push_byte($urandom_range(0, 1) ? 8'h61 : CH_BSL, 1'b1);
          else push_byte(CH_QUOTE, e == 1);
        end
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (text_bytes.size() != 0 || s_tvalid || expected_out.size() != 0) @(negedge clk_i);
    repeat (32) @(posedge clk_i);
    while (expected_out.size() != 0) begin
      flag_mismatch("result never arrived, byte", 8'd0, expected_out[0].data);
      void'(expected_out.pop_front());
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_fifo.sv
hdl/jsu_back.sv
hdl/json_string_unescape_utf8.sv
sim/testbench.sv
